// ===== rtl/core/clcd_pkg.sv =====
// ---------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the 4-bit character LCD sequencer
// Request codes, register map, reset timings and the init command table.
// ---------------------------------------------------------------------------
package clcd_pkg;

    // request codes on the input channel
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CMD  = 2'd1,
        OP_DATA = 2'd2,
        OP_POS  = 2'd3
    } t_op;

    // register map
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_EN_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL    = 3'd6;

    // timing values after reset
    localparam logic [7:0]  RST_EN_HIGH  = 8'd3;
    localparam logic [9:0]  RST_GAP      = 10'd50;
    localparam logic [15:0] RST_POWER_ON = 16'd20000;
    localparam logic [15:0] RST_STEP     = 16'd10000;
    localparam logic [15:0] RST_CLEAR    = 16'd10000;
    localparam logic [9:0]  RST_LEAD     = 10'd500;
    localparam logic [9:0]  RST_TRAIL    = 10'd50;

    // LCD command bytes and init nibbles
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] ADDR_LINE0    = 8'h80;
    localparam logic [7:0] ADDR_LINE1    = 8'hC0;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

    // init_index values
    localparam logic [3:0] INIT_FIRST_BYTE = 4'd4;
    localparam logic [3:0] INIT_LAST_NIB   = 4'd3;
    localparam logic [3:0] INIT_LAST_BYTE  = 4'd7;
    localparam logic [3:0] INIT_DONE       = 4'd8;

    // timing registers as one bundle
    typedef struct packed {
        logic [7:0]  en_high;
        logic [9:0]  gap;
        logic [15:0] power_on;
        logic [15:0] step;
        logic [15:0] clear;
        logic [9:0]  lead;
        logic [9:0]  trail;
    } t_cfg;

    // init command table
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISP_ON;
            2'd2:    b = CMD_ENTRY;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/clcd_in_if.sv =====
// ---------------------------------------------------------------------------
// clcd_in_if: request channel of the LCD sequencer
// Valid/ready handshake carrying one request or tick per transfer.
// ---------------------------------------------------------------------------
interface clcd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;

    modport source (output valid, operation, value, row, col, input ready);
    modport sink   (input valid, operation, value, row, col, output ready);
endinterface

// ===== rtl/core/clcd_out_if.sv =====
// ---------------------------------------------------------------------------
// clcd_out_if: result channel of the LCD sequencer
// Valid/ready handshake carrying the pin levels and status after each item.
// ---------------------------------------------------------------------------
interface clcd_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic       enable;
    logic [3:0] bus_nibble;
    logic       busy_res;
    logic       accepted;

    modport source (output valid, reg_select, enable, bus_nibble, busy_res, accepted,
                    input ready);
    modport sink   (input valid, reg_select, enable, bus_nibble, busy_res, accepted,
                    output ready);
endinterface

// ===== rtl/core/clcd_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// clcd_cfg_regs: timing register file
// Write-only registers, masked to their widths; unknown indexes are dropped.
// ---------------------------------------------------------------------------
module clcd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output clcd_pkg::t_cfg                   o_cfg
);

    clcd_pkg::t_cfg r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.en_high  <= clcd_pkg::RST_EN_HIGH;
            r_cfg.gap      <= clcd_pkg::RST_GAP;
            r_cfg.power_on <= clcd_pkg::RST_POWER_ON;
            r_cfg.step     <= clcd_pkg::RST_STEP;
            r_cfg.clear    <= clcd_pkg::RST_CLEAR;
            r_cfg.lead     <= clcd_pkg::RST_LEAD;
            r_cfg.trail    <= clcd_pkg::RST_TRAIL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clcd_pkg::REG_EN_HIGH:  r_cfg.en_high  <= i_cfg_data[7:0];
                clcd_pkg::REG_GAP:      r_cfg.gap      <= i_cfg_data[9:0];
                clcd_pkg::REG_POWER_ON: r_cfg.power_on <= i_cfg_data;
                clcd_pkg::REG_STEP:     r_cfg.step     <= i_cfg_data;
                clcd_pkg::REG_CLEAR:    r_cfg.clear    <= i_cfg_data;
                clcd_pkg::REG_LEAD:     r_cfg.lead     <= i_cfg_data[9:0];
                clcd_pkg::REG_TRAIL:    r_cfg.trail    <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/char_lcd_4bit_sequencer_unit.sv =====
// Output: each item's result is registered and is valid in the cycle after its transfer.
// Throughput: one item per cycle unless o_rsp stalls; the sequencer state and
// result register update in the same edge, and a new item is taken while the result is taken.
// Reset: synchronous, active low; the power-on wait starts at reset with
// default timings, and the result register empties.
// ---------------------------------------------------------------------------
// char_lcd_4bit_sequencer_unit: 4-bit character LCD sequencer
// Runs the power-on init, then sends command, data and position bytes as
// nibble pairs with enable pulses, timed by tick items.
// ---------------------------------------------------------------------------
module char_lcd_4bit_sequencer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    clcd_in_if.sink                          i_req,
    clcd_out_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        PH_POWER, PH_EN_HIGH, PH_GAP, PH_STEP, PH_CLEAR, PH_LEAD, PH_TRAIL, PH_IDLE
    } t_phase;

    clcd_pkg::t_cfg cfg;

    clcd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // sequencer state
    t_phase      r_phase,   n_phase;
    logic [3:0]  r_init,    n_init;
    logic [15:0] r_tick,    n_tick;
    logic [7:0]  r_pend,    n_pend;
    logic        r_low,     n_low;
    logic        r_rs,      n_rs;
    logic [3:0]  r_nib,     n_nib;
    logic        r_trail,   n_trail;
    logic        n_acc;

    // result register
    logic        r_out_valid;
    logic        r_out_rs, r_out_en, r_out_busy, r_out_acc;
    logic [3:0]  r_out_nib;

    logic        take;
    logic [15:0] dur_raw, dur;
    logic        ph_end;
    logic [3:0]  init_inc;
    logic [7:0]  init_next;
    logic [7:0]  pos_addr;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign take        = i_req.valid && i_req.ready;

    // duration of the running phase; zero acts as one
    always_comb begin
        case (r_phase)
            PH_POWER:   dur_raw = cfg.power_on;
            PH_EN_HIGH: dur_raw = {8'd0, cfg.en_high};
            PH_GAP:     dur_raw = {6'd0, cfg.gap};
            PH_STEP:    dur_raw = cfg.step;
            PH_CLEAR:   dur_raw = cfg.clear;
            PH_LEAD:    dur_raw = {6'd0, cfg.lead};
            PH_TRAIL:   dur_raw = {6'd0, cfg.trail};
            default:    dur_raw = 16'd1;
        endcase
        dur = (dur_raw == 16'd0) ? 16'd1 : dur_raw;
    end

    assign ph_end    = ({1'b0, r_tick} + 17'd1) >= {1'b0, dur};
    assign init_inc  = r_init + 4'd1;
    assign init_next = clcd_pkg::init_byte(init_inc[1:0]);
    assign pos_addr  = (i_req.row ? clcd_pkg::ADDR_LINE1 : clcd_pkg::ADDR_LINE0)
                       + {2'b00, i_req.col};

    // next state for one item
    always_comb begin
        n_phase = r_phase;
        n_init  = r_init;
        n_tick  = r_tick;
        n_pend  = r_pend;
        n_low   = r_low;
        n_rs    = r_rs;
        n_nib   = r_nib;
        n_trail = r_trail;
        n_acc   = 1'b0;

        if (i_req.operation == clcd_pkg::OP_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (!ph_end) begin
                    n_tick = r_tick + 16'd1;
                end else begin
                    n_tick = 16'd0;
                    case (r_phase)
                        PH_POWER: begin
                            n_init  = 4'd0;
                            n_nib   = clcd_pkg::NIB_WAKE;
                            n_phase = PH_EN_HIGH;
                        end
                        PH_EN_HIGH: begin
                            n_phase = PH_GAP;
                        end
                        PH_GAP: begin
                            if (r_init < clcd_pkg::INIT_FIRST_BYTE) begin
                                n_phase = PH_STEP;
                            end else if (r_low) begin
                                // second half of the byte
                                n_low   = 1'b0;
                                n_nib   = r_pend[3:0];
                                n_phase = PH_EN_HIGH;
                            end else if (r_init >= clcd_pkg::INIT_FIRST_BYTE &&
                                         r_init <= clcd_pkg::INIT_LAST_BYTE) begin
                                // init command chain
                                if (r_init == clcd_pkg::INIT_LAST_BYTE) begin
                                    n_phase = PH_CLEAR;
                                end else begin
                                    n_init  = init_inc;
                                    n_pend  = init_next;
                                    n_low   = 1'b1;
                                    n_nib   = init_next[7:4];
                                    n_phase = PH_EN_HIGH;
                                end
                            end else if (r_trail) begin
                                if (cfg.trail == 10'd0) begin
                                    n_phase = PH_IDLE;
                                    n_rs    = 1'b0;
                                    n_trail = 1'b0;
                                end else begin
                                    n_phase = PH_TRAIL;
                                end
                            end else if (!r_rs && r_pend == clcd_pkg::CMD_CLEAR) begin
                                n_phase = PH_CLEAR;
                            end else begin
                                n_phase = PH_IDLE;
                                n_rs    = 1'b0;
                                n_trail = 1'b0;
                            end
                        end
                        PH_STEP: begin
                            n_init = init_inc;
                            if (init_inc >= clcd_pkg::INIT_FIRST_BYTE) begin
                                n_pend = clcd_pkg::CMD_FUNC_SET;
                                n_low  = 1'b1;
                                n_nib  = clcd_pkg::CMD_FUNC_SET[7:4];
                            end else begin
                                n_nib = (init_inc == clcd_pkg::INIT_LAST_NIB) ?
                                        clcd_pkg::NIB_FOUR_BIT : clcd_pkg::NIB_WAKE;
                            end
                            n_phase = PH_EN_HIGH;
                        end
                        PH_LEAD: begin
                            n_low   = 1'b1;
                            n_nib   = r_pend[7:4];
                            n_phase = PH_EN_HIGH;
                        end
                        PH_CLEAR: begin
                            n_init  = clcd_pkg::INIT_DONE;
                            n_phase = PH_IDLE;
                            n_rs    = 1'b0;
                            n_trail = 1'b0;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_rs    = 1'b0;
                            n_trail = 1'b0;
                        end
                    endcase
                end
            end
        end else if (r_phase == PH_IDLE) begin
            // request taken while idle
            n_acc   = 1'b1;
            n_tick  = 16'd0;
            n_rs    = (i_req.operation == clcd_pkg::OP_DATA);
            n_trail = (i_req.operation == clcd_pkg::OP_POS);
            if (i_req.operation == clcd_pkg::OP_POS) begin
                n_pend = pos_addr;
                if (cfg.lead == 10'd0) begin
                    n_low   = 1'b1;
                    n_nib   = pos_addr[7:4];
                    n_phase = PH_EN_HIGH;
                end else begin
                    n_phase = PH_LEAD;
                end
            end else begin
                n_pend  = i_req.value;
                n_low   = 1'b1;
                n_nib   = i_req.value[7:4];
                n_phase = PH_EN_HIGH;
            end
        end
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_POWER;
            r_init      <= 4'd0;
            r_tick      <= 16'd0;
            r_pend      <= 8'd0;
            r_low       <= 1'b0;
            r_rs        <= 1'b0;
            r_nib       <= 4'd0;
            r_trail     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase    <= n_phase;
                r_init     <= n_init;
                r_tick     <= n_tick;
                r_pend     <= n_pend;
                r_low      <= n_low;
                r_rs       <= n_rs;
                r_nib      <= n_nib;
                r_trail    <= n_trail;
                // result payload, loaded on each transfer in
                r_out_rs   <= n_rs;
                r_out_en   <= (n_phase == PH_EN_HIGH);
                r_out_nib  <= n_nib;
                r_out_busy <= (n_phase != PH_IDLE);
                r_out_acc  <= n_acc;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.reg_select = r_out_rs;
    assign o_rsp.enable     = r_out_en;
    assign o_rsp.bus_nibble = r_out_nib;
    assign o_rsp.busy_res   = r_out_busy;
    assign o_rsp.accepted   = r_out_acc;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the 4-bit character LCD sequencer
// Drives ticks and requests on the request channel and checks the pin levels and
// status of every result against a cycle-free model of the sequencer or, for typed
// items, fixed values. Runs a short directed plan, then random phases of settings.
// ---------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 6;
    localparam int MAX_REPORTS = 40;

    // index with no register behind it
    localparam logic [clcd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // sequencer phases as the model tracks them
    typedef enum logic [3:0] {
        PH_POWER   = 4'd0,
        PH_EN_HIGH = 4'd1,
        PH_GAP     = 4'd2,
        PH_STEP    = 4'd3,
        PH_CLEAR   = 4'd4,
        PH_LEAD    = 4'd5,
        PH_TRAIL   = 4'd6,
        PH_IDLE    = 4'd7
    } t_lcd_phase;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG,
        ROW_TICKS,
        ROW_SETTLE
    } t_row_kind;

    // pin levels and status after one item
    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
        logic       busy;
        logic       acc;
    } t_pins;

    typedef struct {
        t_row_kind                       kind;
        clcd_pkg::t_op                   op;
        logic [7:0]                      value;
        logic                            rw;
        logic [5:0]                      col;
        logic [clcd_pkg::CFG_IDX_W-1:0]  idx;
        logic [clcd_pkg::CFG_DATA_W-1:0] data;
        bit                              typed;
        t_pins                           want;
    } t_plan_row;

    localparam logic [7:0] INIT_SEQ [4] = '{clcd_pkg::CMD_FUNC_SET, clcd_pkg::CMD_DISP_ON,
                                            clcd_pkg::CMD_ENTRY, clcd_pkg::CMD_CLEAR};

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [clcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [clcd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    clcd_in_if  req_if();
    clcd_out_if rsp_if();

    char_lcd_4bit_sequencer_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // sequencer model state
    clcd_pkg::t_cfg timing;
    t_lcd_phase lcd_ph;
    logic [3:0] init_step;
    logic [15:0] elapsed;
    logic [7:0] byte_q;
    logic       low_next;
    logic       rs_q;
    logic       trail_q;
    logic [3:0] nib_q;

    t_pins     pin_queue[$];
    t_plan_row plan[$];

    bit src_gaps;
    bit sink_stalls;
    int rsp_hold;
    int mismatches;
    int items_sent;
    int requests_taken;
    int requests_refused;
    int results_checked;
    int reg_writes;
    int cycles;

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------
    function automatic void lcd_reset();
        timing.en_high  = clcd_pkg::RST_EN_HIGH;
        timing.gap      = clcd_pkg::RST_GAP;
        timing.power_on = clcd_pkg::RST_POWER_ON;
        timing.step     = clcd_pkg::RST_STEP;
        timing.clear    = clcd_pkg::RST_CLEAR;
        timing.lead     = clcd_pkg::RST_LEAD;
        timing.trail    = clcd_pkg::RST_TRAIL;
        lcd_ph    = PH_POWER;
        init_step = '0;
        elapsed   = '0;
        byte_q    = '0;
        low_next  = 1'b0;
        rs_q      = 1'b0;
        trail_q   = 1'b0;
        nib_q     = '0;
    endfunction

    function automatic void begin_nibble(input logic [3:0] n);
        nib_q   = n;
        lcd_ph  = PH_EN_HIGH;
        elapsed = '0;
    endfunction

    function automatic void begin_byte(input logic [7:0] b);
        byte_q   = b;
        low_next = 1'b1;
        begin_nibble(b[7:4]);
    endfunction

    function automatic void wait_in(input t_lcd_phase p);
        lcd_ph  = p;
        elapsed = '0;
    endfunction

    function automatic void to_idle();
        lcd_ph  = PH_IDLE;
        elapsed = '0;
        rs_q    = 1'b0;
        trail_q = 1'b0;
    endfunction

    // both nibbles of a byte are out: next init byte, trail, clear or idle
    function automatic void byte_finished();
        if (init_step >= clcd_pkg::INIT_FIRST_BYTE && init_step < clcd_pkg::INIT_DONE) begin
            if (init_step == clcd_pkg::INIT_LAST_BYTE) begin
                wait_in(PH_CLEAR);
            end else begin
                init_step = init_step + 4'd1;
                begin_byte(INIT_SEQ[2'(init_step - clcd_pkg::INIT_FIRST_BYTE)]);
            end
        end else if (trail_q) begin
            if (timing.trail == '0) to_idle();
            else wait_in(PH_TRAIL);
        end else if (!rs_q && byte_q == clcd_pkg::CMD_CLEAR) begin
            wait_in(PH_CLEAR);
        end else begin
            to_idle();
        end
    endfunction

    function automatic void phase_finished();
        case (lcd_ph)
            PH_POWER: begin
                init_step = '0;
                begin_nibble(clcd_pkg::NIB_WAKE);
            end
            PH_EN_HIGH: wait_in(PH_GAP);
            PH_GAP: begin
                if (init_step < clcd_pkg::INIT_FIRST_BYTE) begin
                    wait_in(PH_STEP);
                end else if (low_next) begin
                    low_next = 1'b0;
                    begin_nibble(byte_q[3:0]);
                end else begin
                    byte_finished();
                end
            end
            PH_STEP: begin
                init_step = init_step + 4'd1;
                if (init_step >= clcd_pkg::INIT_FIRST_BYTE) begin_byte(INIT_SEQ[0]);
                else begin_nibble(init_step == clcd_pkg::INIT_LAST_NIB ?
                                  clcd_pkg::NIB_FOUR_BIT : clcd_pkg::NIB_WAKE);
            end
            PH_LEAD: begin_byte(byte_q);
            PH_CLEAR: begin
                init_step = clcd_pkg::INIT_DONE;
                to_idle();
            end
            default: to_idle();
        endcase
    endfunction

    // length of the running phase in ticks; zero counts as one
    function automatic int phase_span();
        int d;
        case (lcd_ph)
            PH_POWER:   d = timing.power_on;
            PH_EN_HIGH: d = timing.en_high;
            PH_GAP:     d = timing.gap;
            PH_STEP:    d = timing.step;
            PH_CLEAR:   d = timing.clear;
            PH_LEAD:    d = timing.lead;
            PH_TRAIL:   d = timing.trail;
            default:    d = 1;
        endcase
        return (d == 0) ? 1 : d;
    endfunction

    function automatic t_pins lcd_step(input clcd_pkg::t_op op, input logic [7:0] value,
                                       input logic rw, input logic [5:0] col);
        t_pins p;
        p.acc = 1'b0;
        if (op == clcd_pkg::OP_TICK) begin
            if (lcd_ph != PH_IDLE) begin
                if (int'(elapsed) + 1 >= phase_span()) phase_finished();
                else elapsed = elapsed + 16'd1;
            end
        end else if (lcd_ph == PH_IDLE) begin
            p.acc   = 1'b1;
            trail_q = 1'b0;
            rs_q    = 1'b0;
            case (op)
                clcd_pkg::OP_CMD: begin_byte(value);
                clcd_pkg::OP_DATA: begin
                    rs_q = 1'b1;
                    begin_byte(value);
                end
                default: begin
                    byte_q  = (rw ? clcd_pkg::ADDR_LINE1 : clcd_pkg::ADDR_LINE0)
                              + {2'b00, col};
                    trail_q = 1'b1;
                    if (timing.lead == '0) begin_byte(byte_q);
                    else wait_in(PH_LEAD);
                end
            endcase
        end
        p.rs   = rs_q;
        p.en   = (lcd_ph == PH_EN_HIGH);
        p.nib  = nib_q;
        p.busy = (lcd_ph != PH_IDLE);
        return p;
    endfunction

    function automatic void lcd_write_reg(input logic [clcd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [clcd_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            clcd_pkg::REG_EN_HIGH:  timing.en_high  = data[7:0];
            clcd_pkg::REG_GAP:      timing.gap      = data[9:0];
            clcd_pkg::REG_POWER_ON: timing.power_on = data;
            clcd_pkg::REG_STEP:     timing.step     = data;
            clcd_pkg::REG_CLEAR:    timing.clear    = data;
            clcd_pkg::REG_LEAD:     timing.lead     = data[9:0];
            clcd_pkg::REG_TRAIL:    timing.trail    = data[9:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // plan building
    // ------------------------------------------------------------------
    function automatic void plan_item(input clcd_pkg::t_op op, input logic [7:0] value,
                                      input logic rw, input logic [5:0] col,
                                      input bit typed, input t_pins want);
        t_plan_row r;
        r.kind  = ROW_ITEM;
        r.op    = op;
        r.value = value;
        r.rw    = rw;
        r.col   = col;
        r.idx   = '0;
        r.data  = '0;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endfunction

    function automatic void plan_ctl(input t_row_kind kind,
                                     input logic [clcd_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [clcd_pkg::CFG_DATA_W-1:0] data);
        t_plan_row r;
        r.kind  = kind;
        r.op    = clcd_pkg::OP_TICK;
        r.value = '0;
        r.rw    = 1'b0;
        r.col   = '0;
        r.idx   = idx;
        r.data  = data;
        r.typed = 1'b0;
        r.want  = '0;
        plan.push_back(r);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_pin(input string name, input logic [3:0] got, input logic [3:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h (result %0d)",
                                      name, got, want, results_checked));
    endtask

    always @(posedge i_clk) begin
        t_pins want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pin_queue.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pin_queue.pop_front();
                check_pin("reg_select", {3'b0, rsp_if.reg_select}, {3'b0, want.rs});
                check_pin("enable",     {3'b0, rsp_if.enable},     {3'b0, want.en});
                check_pin("bus_nibble", rsp_if.bus_nibble,         want.nib);
                check_pin("busy",       {3'b0, rsp_if.busy_res},   {3'b0, want.busy});
                check_pin("accepted",   {3'b0, rsp_if.accepted},   {3'b0, want.acc});
            end
            results_checked++;
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_hold = sink_stalls ? pick_gap() : 0;
            rsp_if.ready <= (rsp_hold == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycles, pin_queue.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // one request transfer; returns at the edge where it was taken
    task automatic send_item(input clcd_pkg::t_op op, input logic [7:0] value, input logic rw,
                             input logic [5:0] col, input bit typed, input t_pins want);
        t_pins pred;
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= value;
        req_if.row       <= rw;
        req_if.col       <= col;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pred = lcd_step(op, value, rw, col);
        pin_queue.push_back(typed ? want : pred);
        items_sent++;
        if (op != clcd_pkg::OP_TICK) begin
            if (pred.acc) requests_taken++;
            else requests_refused++;
        end
    endtask

    task automatic send_tick();
        send_item(clcd_pkg::OP_TICK, 8'($urandom), 1'($urandom), 6'($urandom), 1'b0, '0);
    endtask

    task automatic send_request(input clcd_pkg::t_op op);
        logic [7:0] value;
        value = ($urandom_range(0, 9) == 0) ? clcd_pkg::CMD_CLEAR : 8'($urandom);
        send_item(op, value, 1'($urandom), 6'($urandom), 1'b0, '0);
    endtask

    // register write once every result has drained
    task automatic write_reg(input logic [clcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [clcd_pkg::CFG_DATA_W-1:0] data);
        req_if.valid <= 1'b0;
        while (pin_queue.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lcd_write_reg(idx, data);
        reg_writes++;
        @(posedge i_clk);
    endtask

    initial begin
        int phase_end;
        int r;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.operation = clcd_pkg::OP_TICK;
        req_if.value     = '0;
        req_if.row       = 1'b0;
        req_if.col       = '0;
        rsp_if.ready     = 1'b0;
        src_gaps         = 1'b1;
        sink_stalls      = 1'b1;
        lcd_reset();

        // requests refused during the power-on wait
        plan_item(clcd_pkg::OP_CMD,  8'hFF, 1'b0, 6'd0,  1'b1,
                  '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0});
        plan_item(clcd_pkg::OP_DATA, 8'h00, 1'b0, 6'd0,  1'b1,
                  '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0});
        plan_item(clcd_pkg::OP_POS,  8'h00, 1'b1, 6'd63, 1'b1,
                  '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0});
        plan_ctl(ROW_CFG, clcd_pkg::REG_POWER_ON, 16'hFFFF);
        plan_item(clcd_pkg::OP_TICK, 8'h00, 1'b0, 6'd0,  1'b1,
                  '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0});
        // shrink timings in place; zero acts as one, the long init step is cut short later
        plan_ctl(ROW_CFG, clcd_pkg::REG_POWER_ON, 16'h0000);
        plan_ctl(ROW_CFG, clcd_pkg::REG_EN_HIGH,  16'h0000);
        plan_ctl(ROW_CFG, clcd_pkg::REG_GAP,      16'h0000);
        plan_ctl(ROW_CFG, clcd_pkg::REG_STEP,     16'hFFFF);
        plan_ctl(ROW_CFG, clcd_pkg::REG_CLEAR,    16'h0000);
        plan_ctl(ROW_CFG, clcd_pkg::REG_LEAD,     16'h0000);
        plan_ctl(ROW_CFG, clcd_pkg::REG_TRAIL,    16'h0000);
        plan_ctl(ROW_CFG, REG_UNUSED,             16'hFFFF);
        // power-on wait ends: first wake nibble with EN high
        plan_item(clcd_pkg::OP_TICK, 8'h00, 1'b0, 6'd0,  1'b1,
                  '{1'b0, 1'b1, 4'h3, 1'b1, 1'b0});
        plan_ctl(ROW_TICKS, '0, 16'd12);
        plan_ctl(ROW_CFG, clcd_pkg::REG_STEP, 16'h0000);
        plan_ctl(ROW_SETTLE, '0, '0);
        // clear command, and a refused request while it runs
        plan_item(clcd_pkg::OP_CMD,  clcd_pkg::CMD_CLEAR, 1'b0, 6'd0, 1'b1,
                  '{1'b0, 1'b1, 4'h0, 1'b1, 1'b1});
        plan_item(clcd_pkg::OP_DATA, 8'hA5,               1'b0, 6'd0, 1'b1,
                  '{1'b0, 1'b1, 4'h0, 1'b1, 1'b0});
        plan_ctl(ROW_SETTLE, '0, '0);
        // data 0x01 gets no clear wait
        plan_item(clcd_pkg::OP_DATA, clcd_pkg::CMD_CLEAR, 1'b0, 6'd0, 1'b1,
                  '{1'b1, 1'b1, 4'h0, 1'b1, 1'b1});
        plan_ctl(ROW_SETTLE, '0, '0);
        // position with no lead and no trail
        plan_item(clcd_pkg::OP_POS,  8'h00, 1'b0, 6'd0, 1'b1,
                  '{1'b0, 1'b1, 4'h8, 1'b1, 1'b1});
        plan_ctl(ROW_SETTLE, '0, '0);
        // widest timings, upper data bits masked off; lead cut short while it runs
        plan_ctl(ROW_CFG, clcd_pkg::REG_EN_HIGH, 16'hFFFF);
        plan_ctl(ROW_CFG, clcd_pkg::REG_GAP,     16'hFFFF);
        plan_ctl(ROW_CFG, clcd_pkg::REG_LEAD,    16'hFFFF);
        plan_ctl(ROW_CFG, clcd_pkg::REG_TRAIL,   16'hFFFF);
        plan_item(clcd_pkg::OP_POS,  8'h00, 1'b1, 6'd63, 1'b1,
                  '{1'b0, 1'b0, 4'h0, 1'b1, 1'b1});
        plan_ctl(ROW_TICKS, '0, 16'd4);
        plan_ctl(ROW_CFG, clcd_pkg::REG_LEAD,    16'h0001);
        plan_ctl(ROW_CFG, clcd_pkg::REG_EN_HIGH, 16'h0002);
        plan_ctl(ROW_CFG, clcd_pkg::REG_GAP,     16'h0003);
        plan_ctl(ROW_CFG, clcd_pkg::REG_TRAIL,   16'h0002);
        plan_ctl(ROW_SETTLE, '0, '0);
        // longest clear wait, shortened while it runs
        plan_ctl(ROW_CFG, clcd_pkg::REG_CLEAR, 16'hFFFF);
        plan_item(clcd_pkg::OP_CMD, clcd_pkg::CMD_CLEAR, 1'b0, 6'd0, 1'b0, '0);
        plan_ctl(ROW_TICKS, '0, 16'd30);
        plan_ctl(ROW_CFG, clcd_pkg::REG_CLEAR, 16'h0001);
        plan_ctl(ROW_SETTLE, '0, '0);
        // value extremes with short timings, then a tick while idle
        plan_item(clcd_pkg::OP_CMD, 8'h00, 1'b0, 6'd0, 1'b0, '0);
        plan_ctl(ROW_SETTLE, '0, '0);
        plan_item(clcd_pkg::OP_DATA, 8'hFF, 1'b0, 6'd0, 1'b0, '0);
        plan_ctl(ROW_SETTLE, '0, '0);
        plan_item(clcd_pkg::OP_TICK, 8'hFF, 1'b1, 6'd63, 1'b1,
                  '{1'b0, 1'b0, 4'hF, 1'b0, 1'b0});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed plan
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_ITEM: send_item(plan[i].op, plan[i].value, plan[i].rw, plan[i].col,
                                    plan[i].typed, plan[i].want);
                ROW_CFG: write_reg(plan[i].idx, plan[i].data);
                ROW_TICKS: repeat (int'(plan[i].data)) send_tick();
                default: while (lcd_ph != PH_IDLE) send_tick();
            endcase
        end

        // random phases, each with its own timings and idling mix
        for (int p = 0; p < NUM_PHASES; p++) begin
            src_gaps    = (p % 3 != 0);
            sink_stalls = (p % 2 == 1) || (p == 4);
            write_reg(clcd_pkg::REG_EN_HIGH,  {8'($urandom), 8'($urandom_range(0, 3))});
            write_reg(clcd_pkg::REG_GAP,      {6'($urandom), 10'($urandom_range(0, 6))});
            write_reg(clcd_pkg::REG_POWER_ON, 16'($urandom));
            write_reg(clcd_pkg::REG_STEP,     16'($urandom));
            write_reg(clcd_pkg::REG_CLEAR,    16'($urandom_range(0, 12)));
            write_reg(clcd_pkg::REG_LEAD,     {6'($urandom), 10'($urandom_range(0, 6))});
            write_reg(clcd_pkg::REG_TRAIL,    {6'($urandom), 10'($urandom_range(0, 6))});
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    // full transfer: request, then ticks until idle with stray requests
                    send_request(clcd_pkg::t_op'($urandom_range(1, 3)));
                    while (lcd_ph != PH_IDLE) begin
                        if ($urandom_range(0, 19) == 0)
                            send_request(clcd_pkg::t_op'($urandom_range(1, 3)));
                        else
                            send_tick();
                    end
                end else if (r < 90) begin
                    // cut short: request and only a few ticks
                    send_request(clcd_pkg::t_op'($urandom_range(1, 3)));
                    repeat ($urandom_range(0, 4)) send_tick();
                end else begin
                    send_item(clcd_pkg::t_op'($urandom_range(0, 3)), 8'($urandom),
                              1'($urandom), 6'($urandom), 1'b0, '0);
                end
            end
        end

        req_if.valid <= 1'b0;
        while (pin_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items: %0d requests taken, %0d refused, %0d results checked",
                 items_sent, requests_taken, requests_refused, results_checked);
        $display("Init sequence, clear/position waits and %0d register writes over %0d phases",
                 reg_writes, NUM_PHASES);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
